@@ rtl/core/mmcs_pkg.sv @@
// ----------------------------------------------------------------------------
// mmcs_pkg
// Shared types and constants for the min/max contrast stretch block:
// command codes, range and divider widths, output limits.
// ----------------------------------------------------------------------------
package mmcs_pkg;

    // command codes
    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_MEASURE = 2'd1;
    localparam logic [1:0] CMD_CONVERT = 2'd2;

    // widths of the stored range and the serial divider
    localparam int RANGE_W   = 17;
    localparam int DIFF_W    = RANGE_W + 1;
    localparam int OUT_W     = 8;
    localparam int QUOT_BITS = 8;
    localparam int CNT_W     = 3;
    localparam int REM_W     = RANGE_W + 9;

    localparam logic [OUT_W-1:0] PIXEL_MAX = 8'd255;

    typedef logic signed [RANGE_W-1:0] range_t;
    typedef logic [OUT_W-1:0]          pixel8_t;

endpackage

@@ rtl/core/min_max_contrast_stretch.sv @@
// ----------------------------------------------------------------------------
// min_max_contrast_stretch
// Tracks the minimum and maximum of a frame and stretches pixels linearly
// onto 0..255 with round-half-up, using a bit-serial restoring divider.
// ----------------------------------------------------------------------------
// Clear and measure requests complete on acceptance; they can follow back to back.
// Convert: prep, numerator load, eight divider iterations, then output load;
// empty, zero-width or clamped cases skip the numerator load and divider.
// The output load waits while a held result is not taken; the next request is
// taken after the output load. The divider retires one quotient bit per cycle.
// Reset clears the range, the valid flag, the signed setting and result valid.
module min_max_contrast_stretch #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic                           cfg_write_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     command,
    input  logic [15:0]                    pixel_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [mmcs_pkg::OUT_W-1:0]     pixel_out,
    output logic [mmcs_pkg::RANGE_W-1:0]   range_low_out,
    output logic [mmcs_pkg::RANGE_W-1:0]   range_high_out
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PREP   = 3'd1;
    localparam logic [2:0] S_LOAD   = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    localparam int EXT_BITS = mmcs_pkg::RANGE_W - PIXEL_BITS;

    // control state
    logic [2:0]                     state_reg, state_next;
    logic [mmcs_pkg::CNT_W-1:0]     count_reg, count_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           signed_pixels_reg, signed_pixels_next;
    mmcs_pkg::range_t               range_low_reg, range_low_next;
    mmcs_pkg::range_t               range_high_reg, range_high_next;
    logic                           range_valid_reg, range_valid_next;

    // datapath
    mmcs_pkg::range_t               pix_reg, pix_next;
    logic [mmcs_pkg::RANGE_W-1:0]   n_reg, n_next;
    logic [mmcs_pkg::RANGE_W-1:0]   d_reg, d_next;
    logic [mmcs_pkg::REM_W-1:0]     rem_reg, rem_next;
    logic [mmcs_pkg::REM_W-1:0]     dvs_reg, dvs_next;
    mmcs_pkg::pixel8_t              quot_reg, quot_next;
    mmcs_pkg::pixel8_t              pixel_out_reg, pixel_out_next;
    mmcs_pkg::range_t               range_low_out_reg, range_low_out_next;
    mmcs_pkg::range_t               range_high_out_reg, range_high_out_next;

    // combinational helpers
    logic [PIXEL_BITS-1:0]          raw_pix;
    logic                           pix_sign;
    mmcs_pkg::range_t               pix_in_val;
    logic signed [mmcs_pkg::DIFF_W-1:0] diff_n, diff_d;
    logic [mmcs_pkg::REM_W-1:0]     n_wide, d_wide, numerator;
    logic [mmcs_pkg::REM_W-1:0]     rem_sub;

    // pixel read as signed or unsigned per setting
    assign raw_pix    = pixel_in[PIXEL_BITS-1:0];
    assign pix_sign   = signed_pixels_reg & raw_pix[PIXEL_BITS-1];
    assign pix_in_val = {{EXT_BITS{pix_sign}}, raw_pix};

    // offsets from the range minimum
    assign diff_n = {pix_reg[mmcs_pkg::RANGE_W-1], pix_reg}
                  - {range_low_reg[mmcs_pkg::RANGE_W-1], range_low_reg};
    assign diff_d = {range_high_reg[mmcs_pkg::RANGE_W-1], range_high_reg}
                  - {range_low_reg[mmcs_pkg::RANGE_W-1], range_low_reg};

    // numerator 510*n + d
    assign n_wide    = {{(mmcs_pkg::REM_W - mmcs_pkg::RANGE_W){1'b0}}, n_reg};
    assign d_wide    = {{(mmcs_pkg::REM_W - mmcs_pkg::RANGE_W){1'b0}}, d_reg};
    assign numerator = (n_wide << 9) - (n_wide << 1) + d_wide;

    assign rem_sub = rem_reg - dvs_reg;

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign pixel_out      = pixel_out_reg;
    assign range_low_out  = range_low_out_reg;
    assign range_high_out = range_high_out_reg;

    // next-state logic
    always_comb
    begin
        state_next          = state_reg;
        count_next          = count_reg;
        out_valid_next      = out_valid_reg & ~out_ready;
        signed_pixels_next  = signed_pixels_reg;
        range_low_next      = range_low_reg;
        range_high_next     = range_high_reg;
        range_valid_next    = range_valid_reg;
        pix_next            = pix_reg;
        n_next              = n_reg;
        d_next              = d_reg;
        rem_next            = rem_reg;
        dvs_next            = dvs_reg;
        quot_next           = quot_reg;
        pixel_out_next      = pixel_out_reg;
        range_low_out_next  = range_low_out_reg;
        range_high_out_next = range_high_out_reg;

        // configuration write
        if (cfg_write_en)
        begin
            signed_pixels_next = cfg_write_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (command)
                        mmcs_pkg::CMD_CLEAR:
                        begin
                            range_low_next   = '0;
                            range_high_next  = '0;
                            range_valid_next = 1'b0;
                        end
                        mmcs_pkg::CMD_MEASURE:
                        begin
                            if (!range_valid_reg)
                            begin
                                range_low_next   = pix_in_val;
                                range_high_next  = pix_in_val;
                                range_valid_next = 1'b1;
                            end
                            else
                            begin
                                if (pix_in_val < range_low_reg)
                                begin
                                    range_low_next = pix_in_val;
                                end
                                if (pix_in_val > range_high_reg)
                                begin
                                    range_high_next = pix_in_val;
                                end
                            end
                        end
                        mmcs_pkg::CMD_CONVERT:
                        begin
                            pix_next   = pix_in_val;
                            state_next = S_PREP;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            // special cases and offsets
            S_PREP:
            begin
                n_next = diff_n[mmcs_pkg::RANGE_W-1:0];
                d_next = diff_d[mmcs_pkg::RANGE_W-1:0];
                if (!range_valid_reg || !(range_high_reg > range_low_reg)
                    || (pix_reg <= range_low_reg))
                begin
                    quot_next  = '0;
                    state_next = S_FINISH;
                end
                else if (pix_reg >= range_high_reg)
                begin
                    quot_next  = mmcs_pkg::PIXEL_MAX;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_LOAD;
                end
            end
            // load numerator and divisor 2d aligned to the top quotient bit
            S_LOAD:
            begin
                rem_next   = numerator;
                dvs_next   = d_wide << mmcs_pkg::QUOT_BITS;
                quot_next  = '0;
                count_next = mmcs_pkg::CNT_W'(mmcs_pkg::QUOT_BITS - 1);
                state_next = S_DIV;
            end
            // one restoring step per cycle
            S_DIV:
            begin
                if (rem_reg >= dvs_reg)
                begin
                    rem_next  = rem_sub;
                    quot_next = {quot_reg[mmcs_pkg::OUT_W-2:0], 1'b1};
                end
                else
                begin
                    quot_next = {quot_reg[mmcs_pkg::OUT_W-2:0], 1'b0};
                end
                dvs_next = dvs_reg >> 1;
                if (count_reg == '0)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            // hand the result to the output register
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next      = 1'b1;
                    pixel_out_next      = quot_reg;
                    range_low_out_next  = range_low_reg;
                    range_high_out_next = range_high_reg;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            count_reg         <= '0;
            out_valid_reg     <= 1'b0;
            signed_pixels_reg <= 1'b0;
            range_low_reg     <= '0;
            range_high_reg    <= '0;
            range_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            count_reg         <= count_next;
            out_valid_reg     <= out_valid_next;
            signed_pixels_reg <= signed_pixels_next;
            range_low_reg     <= range_low_next;
            range_high_reg    <= range_high_next;
            range_valid_reg   <= range_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        pix_reg            <= pix_next;
        n_reg              <= n_next;
        d_reg              <= d_next;
        rem_reg            <= rem_next;
        dvs_reg            <= dvs_next;
        quot_reg           <= quot_next;
        pixel_out_reg      <= pixel_out_next;
        range_low_out_reg  <= range_low_out_next;
        range_high_out_reg <= range_high_out_next;
    end

endmodule

@@ tb/min_max_contrast_stretch_test.sv @@
// ----------------------------------------------------------------------------
// min_max_contrast_stretch_test
// Self-checking bench for the min/max contrast stretch block. A queue of
// clear, measure and convert requests, with pauses and register writes mixed
// in, feeds a bursty driver. A built-in predictor tracks the frame range and
// computes each stretched pixel, which a monitor compares with the block's
// results under a randomly stalling receiver.
// ----------------------------------------------------------------------------
module min_max_contrast_stretch_test;
    timeunit 1ns;
    timeprecision 1ps;

    // command value the block ignores
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int ITEM_TARGET   = 1950;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 30;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int LONG_HOLD     = 600;
    localparam int FIRST_HOLD_AT = 3000;

    typedef enum logic [1:0] {
        STEP_ITEM,
        STEP_DRAIN,
        STEP_CFG
    } step_kind_e;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_CADENCE
    } rx_mode_e;

    typedef struct {
        step_kind_e  kind;
        logic [1:0]  cmd;
        logic [15:0] pix;
    } stim_step_t;

    typedef struct {
        mmcs_pkg::pixel8_t pixel;
        mmcs_pkg::range_t  low;
        mmcs_pkg::range_t  high;
    } stretch_result_t;

    logic                           clk            = 1'b0;
    logic                           rst_n          = 1'b0;
    logic                           cfg_write_en   = 1'b0;
    logic                           cfg_write_data = 1'b0;
    logic                           in_valid       = 1'b0;
    logic                           in_ready;
    logic [1:0]                     command        = mmcs_pkg::CMD_CLEAR;
    logic [15:0]                    pixel_in       = '0;
    logic                           out_valid;
    logic                           out_ready      = 1'b0;
    logic [mmcs_pkg::OUT_W-1:0]     pixel_out;
    logic [mmcs_pkg::RANGE_W-1:0]   range_low_out;
    logic [mmcs_pkg::RANGE_W-1:0]   range_high_out;

    // predictor state
    logic             signed_mode = 1'b0;
    mmcs_pkg::range_t span_low    = '0;
    mmcs_pkg::range_t span_high   = '0;
    logic             span_seen   = 1'b0;

    stim_step_t      pending_steps[$];
    stretch_result_t stretch_due[$];

    int   item_count = 0;
    int   fault_cnt  = 0;
    bit   req_taken  = 1'b0;
    bit   drain_wait = 1'b0;
    int   quiet_cnt  = 0;
    int   burst_left = 1;

    min_max_contrast_stretch DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .pixel_in       (pixel_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pixel_out      (pixel_out),
        .range_low_out  (range_low_out),
        .range_high_out (range_high_out)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    task automatic add_item(input logic [1:0] cmd, input logic [15:0] pix);
        stim_step_t s;
        s.kind = STEP_ITEM;
        s.cmd  = cmd;
        s.pix  = pix;
        pending_steps.push_back(s);
        if (cmd != CMD_UNUSED)
            item_count++;
    endtask

    // sender waits until every expected result is back, then settles
    task automatic add_drain();
        stim_step_t s;
        s.kind = STEP_DRAIN;
        s.cmd  = mmcs_pkg::CMD_CLEAR;
        s.pix  = '0;
        pending_steps.push_back(s);
    endtask

    task automatic add_config(input logic value);
        stim_step_t s;
        s.kind = STEP_CFG;
        s.cmd  = mmcs_pkg::CMD_CLEAR;
        s.pix  = {15'd0, value};
        pending_steps.push_back(s);
    endtask

    // range tracking and stretch of one accepted request
    task automatic predict_stretch(input logic [1:0] cmd, input logic [15:0] raw);
        mmcs_pkg::range_t p;
        stretch_result_t  r;
        longint           num;
        longint           den;
        p = mmcs_pkg::range_t'({signed_mode & raw[15], raw});
        case (cmd)
            mmcs_pkg::CMD_CLEAR:
            begin
                span_low  = '0;
                span_high = '0;
                span_seen = 1'b0;
            end
            mmcs_pkg::CMD_MEASURE:
            begin
                if (!span_seen)
                begin
                    span_low  = p;
                    span_high = p;
                    span_seen = 1'b1;
                end
                else
                begin
                    if (p < span_low)
                        span_low = p;
                    if (p > span_high)
                        span_high = p;
                end
            end
            mmcs_pkg::CMD_CONVERT:
            begin
                if (!span_seen || span_high <= span_low || p <= span_low)
                    r.pixel = '0;
                else if (p >= span_high)
                    r.pixel = mmcs_pkg::PIXEL_MAX;
                else
                begin
                    num = longint'(p) - longint'(span_low);
                    den = longint'(span_high) - longint'(span_low);
                    r.pixel = mmcs_pkg::pixel8_t'((510 * num + den) / (2 * den));
                end
                r.low  = span_low;
                r.high = span_high;
                stretch_due.push_back(r);
            end
            default:
            begin
            end
        endcase
    endtask

    // sample handshakes, register writes and results at the rising edge
    always @(posedge clk)
    begin : sample_edge
        stretch_result_t want;
        if (rst_n)
        begin
            if (cfg_write_en)
                signed_mode = cfg_write_data;
            if (in_valid && in_ready)
            begin
                predict_stretch(command, pixel_in);
                req_taken = 1'b1;
            end
            if (out_valid && out_ready)
            begin
                if (stretch_due.size() == 0)
                begin
                    $display("%0t: unexpected result pixel_out %0d range %0d..%0d",
                             $time, pixel_out, $signed(range_low_out),
                             $signed(range_high_out));
                    fault_cnt++;
                end
                else
                begin
                    want = stretch_due.pop_front();
                    if (pixel_out !== want.pixel)
                    begin
                        $display("%0t: pixel_out expected %0d actual %0d",
                                 $time, want.pixel, pixel_out);
                        fault_cnt++;
                    end
                    if (range_low_out !== want.low)
                    begin
                        $display("%0t: range_low_out expected %0d actual %0d",
                                 $time, want.low, $signed(range_low_out));
                        fault_cnt++;
                    end
                    if (range_high_out !== want.high)
                    begin
                        $display("%0t: range_high_out expected %0d actual %0d",
                                 $time, want.high, $signed(range_high_out));
                        fault_cnt++;
                    end
                end
            end
        end
    end

    // request driver: bursts with gaps, pauses and register writes
    always @(negedge clk)
    begin : drive_requests
        stim_step_t s;
        logic       nv;
        logic       nwe;
        nv  = in_valid;
        nwe = 1'b0;
        if (rst_n)
        begin
            if (req_taken)
            begin
                nv        = 1'b0;
                req_taken = 1'b0;
            end
            if (!nv)
            begin
                if (quiet_cnt > 0)
                    quiet_cnt--;
                else if (drain_wait)
                begin
                    if (stretch_due.size() == 0)
                    begin
                        drain_wait = 1'b0;
                        quiet_cnt  = SETTLE_CYCLES;
                    end
                end
                else if (pending_steps.size() != 0)
                begin
                    s = pending_steps.pop_front();
                    case (s.kind)
                        STEP_ITEM:
                        begin
                            nv = 1'b1;
                            command  <= s.cmd;
                            pixel_in <= s.pix;
                            burst_left--;
                            if (burst_left == 0)
                            begin
                                burst_left = $urandom_range(1, 40);
                                quiet_cnt  = ($urandom_range(0, 3) == 0) ? 0
                                             : $urandom_range(1, 8);
                            end
                        end
                        STEP_DRAIN:
                            drain_wait = 1'b1;
                        STEP_CFG:
                        begin
                            nwe = 1'b1;
                            cfg_write_data <= s.pix[0];
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
        in_valid     <= nv;
        cfg_write_en <= nwe;
    end

    // result receiver: stall patterns plus occasional long hold-offs
    always @(negedge clk)
    begin : drive_ready
        static int       rx_cycle     = 0;
        static int       hold_cnt     = 0;
        static int       long_holds   = 0;
        static int       next_long_at = FIRST_HOLD_AT;
        static int       mode_left    = 0;
        static rx_mode_e mode         = RX_OPEN;
        logic            nr;
        rx_cycle++;
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            nr = 1'b0;
        end
        else if (long_holds < 3 && rx_cycle >= next_long_at && in_valid)
        begin
            hold_cnt     = LONG_HOLD;
            long_holds++;
            next_long_at = rx_cycle + $urandom_range(8000, 20000);
            nr           = 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                mode      = rx_mode_e'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                RX_OPEN:    nr = 1'b1;
                RX_COIN:    nr = 1'($urandom_range(0, 1));
                RX_SPARSE:  nr = ($urandom_range(0, 3) == 0);
                RX_CADENCE: nr = ((rx_cycle % 3) != 0);
                default:    nr = 1'b1;
            endcase
        end
        out_ready <= nr;
    end

    initial
    begin : run_control
        logic [15:0] base;
        logic [15:0] pix;
        int          spread;
        int          n_meas;
        int          frame_no;
        int          sel;
        int          waited;
        bit          timed_out;

        // directed: empty range, ignored command, zero width, extremes
        add_config(1'b0);
        add_item(mmcs_pkg::CMD_CONVERT, 16'h1234);
        add_item(CMD_UNUSED, 16'hFFFF);
        add_item(mmcs_pkg::CMD_MEASURE, 16'd5);
        add_item(mmcs_pkg::CMD_CONVERT, 16'd5);
        add_item(mmcs_pkg::CMD_MEASURE, 16'h0000);
        add_item(mmcs_pkg::CMD_MEASURE, 16'hFFFF);
        add_item(mmcs_pkg::CMD_CONVERT, 16'h0000);
        add_item(mmcs_pkg::CMD_CONVERT, 16'hFFFF);
        add_item(mmcs_pkg::CMD_CONVERT, 16'h8000);
        add_item(mmcs_pkg::CMD_CLEAR, 16'hAAAA);
        // signed pixels over the full range
        add_drain();
        add_config(1'b1);
        add_item(mmcs_pkg::CMD_MEASURE, 16'h8000);
        add_item(mmcs_pkg::CMD_MEASURE, 16'h7FFF);
        add_item(mmcs_pkg::CMD_CONVERT, 16'h8000);
        add_item(mmcs_pkg::CMD_CONVERT, 16'h7FFF);
        add_item(mmcs_pkg::CMD_CONVERT, 16'hFFFF);
        add_item(mmcs_pkg::CMD_CONVERT, 16'h0001);
        // register change mid-frame keeps the stored bounds
        add_drain();
        add_config(1'b0);
        add_item(mmcs_pkg::CMD_CONVERT, 16'hFFFF);
        add_item(mmcs_pkg::CMD_MEASURE, 16'hFFFF);
        add_item(mmcs_pkg::CMD_CONVERT, 16'h8000);
        // rounding tie, below and above the range
        add_item(mmcs_pkg::CMD_CLEAR, 16'h5555);
        add_item(mmcs_pkg::CMD_MEASURE, 16'd100);
        add_item(mmcs_pkg::CMD_MEASURE, 16'd102);
        add_item(mmcs_pkg::CMD_CONVERT, 16'd101);
        add_item(mmcs_pkg::CMD_CONVERT, 16'd50);
        add_item(mmcs_pkg::CMD_CONVERT, 16'd200);

        // random frames: clear, measure pass, convert pass, some noise
        frame_no = 0;
        while (item_count < ITEM_TARGET)
        begin
            frame_no++;
            if (frame_no % 5 == 0)
            begin
                add_drain();
                add_config(1'($urandom_range(0, 1)));
            end
            else if ($urandom_range(0, 7) == 0)
                add_drain();
            base = 16'($urandom);
            case ($urandom_range(0, 4))
                0:       spread = 0;
                1:       spread = $urandom_range(1, 3);
                2:       spread = $urandom_range(4, 255);
                3:       spread = $urandom_range(256, 4095);
                default: spread = 65535;
            endcase
            n_meas = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
            if ($urandom_range(0, 9) != 0)
                add_item(mmcs_pkg::CMD_CLEAR, 16'($urandom));
            repeat (n_meas)
                add_item(mmcs_pkg::CMD_MEASURE, 16'(base + $urandom_range(0, spread)));
            repeat ($urandom_range(1, 12))
            begin
                sel = $urandom_range(0, 11);
                if (sel < 8)
                    add_item(mmcs_pkg::CMD_CONVERT,
                             16'(base + $urandom_range(0, spread)));
                else if (sel < 10)
                    add_item(mmcs_pkg::CMD_CONVERT, 16'($urandom));
                else
                begin
                    pix = 16'($urandom);
                    add_item(2'($urandom_range(0, 3)), pix);
                end
            end
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // wait for the stimulus to drain and every result to come back
        waited = 0;
        while ((pending_steps.size() != 0 || in_valid || drain_wait ||
                stretch_due.size() != 0) && waited < CYCLE_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        timed_out = (waited >= CYCLE_LIMIT);
        if (!timed_out)
            repeat (TAIL_CYCLES) @(posedge clk);
        if (!timed_out && fault_cnt == 0)
            $display("min_max_contrast_stretch: match");
        else
            $display("min_max_contrast_stretch: mismatch");
        $finish;
    end

endmodule
